@@ hw/rtl/dqp_pkg.sv @@
// Package for the double-ended priority queue: sizes, command and status codes,
// cell operation codes, and the entry and scan record types.
// No dependencies.
package dqp_pkg;

	localparam int DEPTH  = 16;
	localparam int IDX_W  = $clog2(DEPTH);
	localparam int CNT_W  = $clog2(DEPTH + 1);
	localparam int CMD_W  = 3;
	localparam int DATA_W = 32;
	localparam int STAT_W = 2;
	localparam int OCC_W  = 5;

	localparam logic [CMD_W-1:0] CMD_PUSH_FRONT = 3'd0;
	localparam logic [CMD_W-1:0] CMD_PUSH_REAR  = 3'd1;
	localparam logic [CMD_W-1:0] CMD_POP_FRONT  = 3'd2;
	localparam logic [CMD_W-1:0] CMD_POP_REAR   = 3'd3;
	localparam logic [CMD_W-1:0] CMD_POP_MAX    = 3'd4;

	localparam logic [STAT_W-1:0] ST_DONE  = 2'd0;
	localparam logic [STAT_W-1:0] ST_EMPTY = 2'd1;
	localparam logic [STAT_W-1:0] ST_FULL  = 2'd2;

	typedef enum logic [1:0] {
		OP_HOLD  = 2'd0,
		OP_LOAD  = 2'd1,
		OP_LEFT  = 2'd2,
		OP_RIGHT = 2'd3
	} cell_op_t;

	typedef enum logic [2:0] {
		S_IDLE = 3'b001,
		S_SCAN = 3'b010,
		S_EXEC = 3'b100
	} state_t;

	typedef struct packed {
		logic signed [DATA_W-1:0] val;
		logic signed [DATA_W-1:0] pri;
	} entry_t;

	typedef struct packed {
		logic                     found;
		logic [IDX_W-1:0]         idx;
		logic signed [DATA_W-1:0] val;
		logic signed [DATA_W-1:0] pri;
	} scan_t;

endpackage

@@ hw/rtl/dqp_cmd_if.sv @@
// Command channel: valid/ready handshake carrying one queue command.
// Depends on dqp_pkg.
interface dqp_cmd_if;
	import dqp_pkg::*;

	logic                     valid;
	logic                     ready;
	logic [CMD_W-1:0]         command;
	logic signed [DATA_W-1:0] entry_value;
	logic signed [DATA_W-1:0] entry_priority;

	modport source (output valid, command, entry_value, entry_priority, input ready);
	modport sink (input valid, command, entry_value, entry_priority, output ready);
endinterface

@@ hw/rtl/dqp_rsp_if.sv @@
// Response channel: valid/ready handshake carrying one command result.
// Depends on dqp_pkg.
interface dqp_rsp_if;
	import dqp_pkg::*;

	logic                     valid;
	logic                     ready;
	logic signed [DATA_W-1:0] removed_value;
	logic [STAT_W-1:0]        status;
	logic [OCC_W-1:0]         occupancy;

	modport source (output valid, removed_value, status, occupancy, input ready);
	modport sink (input valid, removed_value, status, occupancy, output ready);
endinterface

@@ hw/rtl/dqp_cell.sv @@
// One storage cell of the queue chain: holds an entry, shifts with its neighbors,
// and runs one step of the max-priority scan wavefront. Depends on dqp_pkg.
module dqp_cell (
	input  logic                    clk,
	input  dqp_pkg::cell_op_t       op,
	input  dqp_pkg::entry_t         load_entry,
	input  dqp_pkg::entry_t         left_entry,
	input  dqp_pkg::entry_t         right_entry,
	input  logic                    member,
	input  logic [dqp_pkg::IDX_W-1:0] cell_idx,
	input  dqp_pkg::scan_t          scan_in,
	output dqp_pkg::entry_t         entry,
	output dqp_pkg::scan_t          scan_out
);
	import dqp_pkg::*;

	entry_t entry_q;
	scan_t  scan_q;
	logic   take;

	always_ff @(posedge clk) begin
		unique case (op)
			OP_HOLD:  entry_q <= entry_q;
			OP_LOAD:  entry_q <= load_entry;
			OP_LEFT:  entry_q <= left_entry;
			OP_RIGHT: entry_q <= right_entry;
			default:  entry_q <= entry_q;
		endcase
	end

	// strict compare: the frontmost of equal priorities stays the winner
	assign take = member && (!scan_in.found || ($signed(entry_q.pri) > $signed(scan_in.pri)));

	always_ff @(posedge clk) begin
		if (take) begin
			scan_q.found <= 1'b1;
			scan_q.idx   <= cell_idx;
			scan_q.val   <= entry_q.val;
			scan_q.pri   <= entry_q.pri;
		end else begin
			scan_q <= scan_in;
		end
	end

	assign entry    = entry_q;
	assign scan_out = scan_q;
endmodule

@@ hw/rtl/deque_with_max_priority_removal_core.sv @@
// Top level of the double-ended priority queue: command sequencer, result
// register and a chain of dqp_cell. Depends on dqp_pkg, dqp_cmd_if, dqp_rsp_if.
//
//  channel  dir  payload                                   transaction
//  cmd      in   command, entry_value, entry_priority      valid & ready
//  rsp      out  removed_value, status, occupancy          valid & ready
//
// Push front/rear, pop front/rear: accept, then one cell update.
// Pop highest priority: accept, scan, update; the scan wavefront crosses the cell chain
// one cell per cycle. Empty-store pops skip the scan.
// Reset clears the count, sequencer and response valid; cell contents are not reset.
// A result waiting on rsp stalls only the update step of the next command.
module deque_with_max_priority_removal_core (
	input  logic        clk,
	input  logic        arst_n,
	dqp_cmd_if.sink     cmd,
	dqp_rsp_if.source   rsp
);
	import dqp_pkg::*;

	state_t                   state_q;
	logic [CNT_W-1:0]         count_q;
	logic [CMD_W-1:0]         cmd_q;
	logic signed [DATA_W-1:0] val_q;
	logic signed [DATA_W-1:0] pri_q;
	logic [IDX_W-1:0]         scan_cnt_q;

	logic                     rsp_valid_q;
	logic signed [DATA_W-1:0] removed_q;
	logic [STAT_W-1:0]        status_q;
	logic [OCC_W-1:0]         occ_q;

	entry_t   cells   [DEPTH];
	scan_t    scans   [DEPTH];
	cell_op_t ops     [DEPTH];
	logic     member  [DEPTH];
	entry_t   load_entry;

	logic                     out_free;
	logic                     fire_exec;
	logic                     full;
	logic                     empty;
	logic signed [DATA_W-1:0] rear_val;
	logic signed [DATA_W-1:0] removed_d;
	logic [STAT_W-1:0]        status_d;
	logic [CNT_W-1:0]         count_d;

	assign out_free  = !rsp_valid_q || rsp.ready;
	assign fire_exec = (state_q == S_EXEC) && out_free;
	assign full      = (count_q == CNT_W'(DEPTH));
	assign empty     = (count_q == '0);
	assign cmd.ready = (state_q == S_IDLE);

	assign load_entry.val = val_q;
	assign load_entry.pri = pri_q;

	genvar g;
	generate
		for (g = 0; g < DEPTH; g++) begin : g_cell
			entry_t left_e;
			entry_t right_e;
			scan_t  scan_i;
			if (g == 0) begin : g_first
				assign left_e = cells[g];
				assign scan_i = '0;
			end else begin : g_mid
				assign left_e = cells[g-1];
				assign scan_i = scans[g-1];
			end
			if (g == DEPTH - 1) begin : g_last
				assign right_e = cells[g];
			end else begin : g_notlast
				assign right_e = cells[g+1];
			end
			assign member[g] = (CNT_W'(g) < count_q);

			dqp_cell u_cell (
				.clk         (clk),
				.op          (ops[g]),
				.load_entry  (load_entry),
				.left_entry  (left_e),
				.right_entry (right_e),
				.member      (member[g]),
				.cell_idx    (IDX_W'(g)),
				.scan_in     (scan_i),
				.entry       (cells[g]),
				.scan_out    (scans[g])
			);
		end
	endgenerate

	always_comb begin
		rear_val = '0;
		for (int i = 0; i < DEPTH; i++) begin
			if (CNT_W'(i) == count_q - CNT_W'(1)) begin
				rear_val = rear_val | cells[i].val;
			end
		end
	end

	always_comb begin
		for (int i = 0; i < DEPTH; i++) begin
			ops[i] = OP_HOLD;
		end
		removed_d = '0;
		status_d  = ST_DONE;
		count_d   = count_q;
		unique case (cmd_q)
			CMD_PUSH_FRONT: begin
				if (full) begin
					status_d = ST_FULL;
				end else begin
					count_d = count_q + CNT_W'(1);
					for (int i = 0; i < DEPTH; i++) begin
						ops[i] = (i == 0) ? OP_LOAD : OP_LEFT;
					end
				end
			end
			CMD_PUSH_REAR: begin
				if (full) begin
					status_d = ST_FULL;
				end else begin
					count_d = count_q + CNT_W'(1);
					for (int i = 0; i < DEPTH; i++) begin
						if (CNT_W'(i) == count_q) begin
							ops[i] = OP_LOAD;
						end
					end
				end
			end
			CMD_POP_FRONT: begin
				if (empty) begin
					status_d = ST_EMPTY;
				end else begin
					count_d   = count_q - CNT_W'(1);
					removed_d = cells[0].val;
					for (int i = 0; i < DEPTH; i++) begin
						ops[i] = OP_RIGHT;
					end
				end
			end
			CMD_POP_REAR: begin
				if (empty) begin
					status_d = ST_EMPTY;
				end else begin
					count_d   = count_q - CNT_W'(1);
					removed_d = rear_val;
				end
			end
			CMD_POP_MAX: begin
				if (empty) begin
					status_d = ST_EMPTY;
				end else begin
					count_d   = count_q - CNT_W'(1);
					removed_d = scans[DEPTH-1].val;
					for (int i = 0; i < DEPTH; i++) begin
						if (IDX_W'(i) >= scans[DEPTH-1].idx) begin
							ops[i] = OP_RIGHT;
						end
					end
				end
			end
			default: ;
		endcase
		if (!fire_exec) begin
			for (int i = 0; i < DEPTH; i++) begin
				ops[i] = OP_HOLD;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			count_q    <= '0;
			scan_cnt_q <= '0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (cmd.valid) begin
						scan_cnt_q <= '0;
						if (cmd.command == CMD_POP_MAX && !empty) begin
							state_q <= S_SCAN;
						end else begin
							state_q <= S_EXEC;
						end
					end
				end
				S_SCAN: begin
					scan_cnt_q <= scan_cnt_q + IDX_W'(1);
					if (scan_cnt_q == IDX_W'(DEPTH - 1)) begin
						state_q <= S_EXEC;
					end
				end
				S_EXEC: begin
					if (out_free) begin
						count_q <= count_d;
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.valid && cmd.ready) begin
			cmd_q <= cmd.command;
			val_q <= cmd.entry_value;
			pri_q <= cmd.entry_priority;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (fire_exec) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fire_exec) begin
			removed_q <= removed_d;
			status_q  <= status_d;
			occ_q     <= OCC_W'(count_d);
		end
	end

	assign rsp.valid         = rsp_valid_q;
	assign rsp.removed_value = removed_q;
	assign rsp.status        = status_q;
	assign rsp.occupancy     = occ_q;

	a_exec_gives_rsp: assert property (@(posedge clk) disable iff (!arst_n)
		fire_exec |=> rsp_valid_q)
		else $error("update step did not produce a response");

	a_occ_matches_count: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid_q |-> (occ_q == OCC_W'(count_q)))
		else $error("reported occupancy differs from held count");

	a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.valid && cmd.ready) |=> (state_q != S_IDLE))
		else $error("accepted transaction not processed");

	a_scan_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_SCAN) |-> (!empty && count_q <= CNT_W'(DEPTH)))
		else $error("priority scan on empty or overfull store");
endmodule

@@ verif/deque_with_max_priority_removal_core_test.sv @@
// Testbench for deque_with_max_priority_removal_core: directed table, then random
// fill/drain traffic checked against an in-bench model of the deque.
// Depends on dqp_pkg, dqp_cmd_if, dqp_rsp_if and the core.
module deque_with_max_priority_removal_core_test;
	import dqp_pkg::*;

	localparam logic [CMD_W-1:0] CMD_UNUSED_LO = 3'd5;
	localparam logic [CMD_W-1:0] CMD_UNUSED_HI = 3'd7;
	localparam int RAND_PER_PHASE = 600;
	localparam int DIR_N = 15;

	typedef struct packed {
		logic signed [DATA_W-1:0] removed;
		logic [STAT_W-1:0]        status;
		logic [OCC_W-1:0]         occ;
	} dq_res_t;

	typedef struct {
		logic [CMD_W-1:0]         cmd;
		logic signed [DATA_W-1:0] val;
		logic signed [DATA_W-1:0] pri;
		int                       reps;
		bit                       typed;
		dq_res_t                  res;
	} dir_row_t;

	logic clk;
	logic arst_n;

	dqp_cmd_if cmd_ch ();
	dqp_rsp_if rsp_ch ();

	deque_with_max_priority_removal_core dut (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd_ch),
		.rsp    (rsp_ch)
	);

	// model of the deque contents
	logic signed [DATA_W-1:0] dq_val [DEPTH];
	logic signed [DATA_W-1:0] dq_pri [DEPTH];
	int dq_cnt = 0;

	dq_res_t pending_res [$];
	int err_cnt = 0;
	int send_idle_pct = 0;
	int recv_stall_pct = 0;
	bit pin_typed = 1'b0;
	dq_res_t pin_res = '0;

	// typed rows: empty pops, unused commands, first pushes, pushes on full
	dir_row_t dir_tab [DIR_N] = '{
		'{CMD_POP_FRONT, 32'sd0, 32'sd0, 1, 1'b1, '{32'sd0, ST_EMPTY, 5'd0}},
		'{CMD_POP_REAR, -32'sd1, -32'sd1, 1, 1'b1, '{32'sd0, ST_EMPTY, 5'd0}},
		'{CMD_POP_MAX, 32'sd0, 32'sd0, 1, 1'b1, '{32'sd0, ST_EMPTY, 5'd0}},
		'{CMD_UNUSED_LO, 32'sd0, 32'sd0, 1, 1'b1, '{32'sd0, ST_DONE, 5'd0}},
		'{CMD_UNUSED_HI, -32'sd1, -32'sd1, 1, 1'b1, '{32'sd0, ST_DONE, 5'd0}},
		'{CMD_PUSH_REAR, 32'sh7fffffff, 32'sh80000000, 1, 1'b1, '{32'sd0, ST_DONE, 5'd1}},
		'{CMD_PUSH_FRONT, 32'sh80000000, 32'sh7fffffff, 1, 1'b1, '{32'sd0, ST_DONE, 5'd2}},
		'{CMD_PUSH_REAR, 32'sd0, 32'sh7fffffff, 1, 1'b1, '{32'sd0, ST_DONE, 5'd3}},
		'{CMD_PUSH_REAR, 32'sh12345678, -32'sd6, 13, 1'b0, '0},
		'{CMD_PUSH_REAR, 32'sd1, 32'sd1, 1, 1'b1, '{32'sd0, ST_FULL, 5'd16}},
		'{CMD_PUSH_FRONT, -32'sd1, -32'sd1, 1, 1'b1, '{32'sd0, ST_FULL, 5'd16}},
		'{CMD_POP_MAX, 32'sd0, 32'sd0, 1, 1'b0, '0},
		'{CMD_POP_MAX, -32'sd1, -32'sd1, 1, 1'b0, '0},
		'{CMD_POP_REAR, 32'sd0, 32'sd0, 1, 1'b0, '0},
		'{CMD_POP_FRONT, 32'sd0, 32'sd0, 1, 1'b0, '0}
	};

	always begin
		clk = 1'b1;
		#4;
		clk = 1'b0;
		#4;
	end

	function automatic dq_res_t dq_apply(input logic [CMD_W-1:0] c,
			input logic signed [DATA_W-1:0] v, input logic signed [DATA_W-1:0] p);
		dq_res_t r;
		int best;
		r = '0;
		r.status = ST_DONE;
		case (c)
			CMD_PUSH_FRONT, CMD_PUSH_REAR: begin
				if (dq_cnt >= DEPTH) begin
					r.status = ST_FULL;
				end else if (c == CMD_PUSH_FRONT) begin
					for (int i = dq_cnt; i > 0; i--) begin
						dq_val[i] = dq_val[i-1];
						dq_pri[i] = dq_pri[i-1];
					end
					dq_val[0] = v;
					dq_pri[0] = p;
					dq_cnt++;
				end else begin
					dq_val[dq_cnt] = v;
					dq_pri[dq_cnt] = p;
					dq_cnt++;
				end
			end
			CMD_POP_FRONT, CMD_POP_REAR, CMD_POP_MAX: begin
				if (dq_cnt == 0) begin
					r.status = ST_EMPTY;
				end else begin
					best = (c == CMD_POP_REAR) ? dq_cnt - 1 : 0;
					if (c == CMD_POP_MAX)
						for (int i = 1; i < dq_cnt; i++)
							if (dq_pri[i] > dq_pri[best])
								best = i;
					r.removed = dq_val[best];
					for (int i = best; i < dq_cnt - 1; i++) begin
						dq_val[i] = dq_val[i+1];
						dq_pri[i] = dq_pri[i+1];
					end
					dq_cnt--;
				end
			end
			default: ;
		endcase
		r.occ = OCC_W'(dq_cnt);
		return r;
	endfunction

	function automatic logic signed [DATA_W-1:0] pick_pri();
		case ($urandom_range(9))
			0: return 32'sh7fffffff;
			1: return 32'sh80000000;
			2, 3, 4: return $signed(32'($urandom_range(6))) - 32'sd3;
			default: return $signed($urandom);
		endcase
	endfunction

	task automatic issue(input logic [CMD_W-1:0] c, input logic signed [DATA_W-1:0] v,
			input logic signed [DATA_W-1:0] p, input bit typed, input dq_res_t tres);
		@(negedge clk);
		while ($urandom_range(99) < send_idle_pct) begin
			cmd_ch.valid <= 1'b0;
			@(negedge clk);
		end
		cmd_ch.valid <= 1'b1;
		cmd_ch.command <= c;
		cmd_ch.entry_value <= v;
		cmd_ch.entry_priority <= p;
		pin_typed = typed;
		pin_res = tres;
		@(posedge clk);
		while (!cmd_ch.ready)
			@(posedge clk);
	endtask

	task automatic drain_wait();
		@(negedge clk);
		cmd_ch.valid <= 1'b0;
		wait (pending_res.size() == 0);
	endtask

	// transaction monitor: predict on command, check on response
	always @(posedge clk) begin
		dq_res_t got;
		dq_res_t want;
		if (arst_n) begin
			if (rsp_ch.valid && rsp_ch.ready) begin
				got = '{rsp_ch.removed_value, rsp_ch.status, rsp_ch.occupancy};
				if (pending_res.size() == 0) begin
					$error("unexpected response transaction");
					err_cnt++;
				end else begin
					want = pending_res.pop_front();
					if (got.removed !== want.removed) begin
						$error("removed_value: expected %0d, got %0d", want.removed, got.removed);
						err_cnt++;
					end
					if (got.status !== want.status) begin
						$error("status: expected %0d, got %0d", want.status, got.status);
						err_cnt++;
					end
					if (got.occ !== want.occ) begin
						$error("occupancy: expected %0d, got %0d", want.occ, got.occ);
						err_cnt++;
					end
				end
			end
			if (cmd_ch.valid && cmd_ch.ready) begin
				want = dq_apply(cmd_ch.command, cmd_ch.entry_value, cmd_ch.entry_priority);
				if (pin_typed)
					want = pin_res;
				pending_res.push_back(want);
			end
		end
	end

	initial begin
		rsp_ch.ready = 1'b0;
		forever begin
			@(negedge clk);
			rsp_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
		end
	end

	initial begin
		logic [CMD_W-1:0] c;
		logic signed [DATA_W-1:0] v;
		int r;
		bit fill;
		arst_n = 1'b0;
		cmd_ch.valid = 1'b0;
		cmd_ch.command = '0;
		cmd_ch.entry_value = '0;
		cmd_ch.entry_priority = '0;
		fill = 1'b1;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		send_idle_pct = 9;
		recv_stall_pct = 50;
		foreach (dir_tab[i])
			for (int k = 0; k < dir_tab[i].reps; k++)
				issue(dir_tab[i].cmd, dir_tab[i].val + k, dir_tab[i].pri + k,
					dir_tab[i].typed, dir_tab[i].res);

		for (int ph = 0; ph < 3; ph++) begin
			drain_wait();
			send_idle_pct = (ph == 0) ? 9 : (ph == 1) ? 50 : 0;
			recv_stall_pct = (ph == 0) ? 50 : (ph == 1) ? 9 : 0;
			for (int n = 0; n < RAND_PER_PHASE; n++) begin
				if (dq_cnt >= DEPTH)
					fill = 1'b0;
				else if (dq_cnt == 0)
					fill = 1'b1;
				else if ($urandom_range(99) < 4)
					fill = !fill;
				r = $urandom_range(99);
				if (r < 3) begin
					c = CMD_W'($urandom_range(CMD_UNUSED_HI, CMD_UNUSED_LO));
				end else if ((r < 72) == fill) begin
					c = $urandom_range(1) ? CMD_PUSH_REAR : CMD_PUSH_FRONT;
				end else begin
					case ($urandom_range(3))
						0: c = CMD_POP_FRONT;
						1: c = CMD_POP_REAR;
						default: c = CMD_POP_MAX;
					endcase
				end
				v = ($urandom_range(19) == 0) ? pick_pri() : $signed($urandom);
				issue(c, v, pick_pri(), 1'b0, '0);
			end
		end

		drain_wait();
		repeat (4 * DEPTH) @(posedge clk);
		if (pending_res.size() != 0) begin
			$error("%0d responses never arrived", pending_res.size());
			err_cnt++;
		end
		if (err_cnt == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

	initial begin
		#4000000;
		$display("Simulation FAILED");
		$finish;
	end

endmodule
